### rtl/mcp_pkg.sv
// Shared types for the midpoint circle point generator.
// Used by mcp_emit and midpoint_circle_points_top; no dependencies.
package mcp_pkg;

  // What a burst of results looks like
  typedef enum logic [2:0] {
    KIND_INVALID,  // one result, no point, flagged done
    KIND_CENTRE,   // one result, the centre itself
    KIND_AXIS,     // four axis points at distance dx
    KIND_QUAD,     // four points, diagonal case (x == y)
    KIND_OCT       // eight reflected points
  } kind_t;

  // Control part of a burst handed from the stepper to the emitter
  typedef struct packed {
    kind_t kind;
    logic  done;
  } burst_ctrl_t;

  localparam int unsigned IDX_BITS = 3;

endpackage

### rtl/mcp_emit.sv
// Point emitter: walks one burst, one result per cycle when the output is not stalled, into an output register.
// Depends on mcp_pkg.
module mcp_emit #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      burst_valid,
  input  mcp_pkg::burst_ctrl_t                      burst_ctrl,
  input  logic [COORD_BITS-1:0]                     burst_cx,
  input  logic [COORD_BITS-1:0]                     burst_cy,
  input  logic [RADIUS_BITS-1:0]                    burst_dx,
  input  logic [RADIUS_BITS-1:0]                    burst_dy,
  output logic                                      burst_take,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // point_x, point_y, zero pad
  output logic [(((2*(COORD_BITS+1))+7)/8)*8-1:0]   m_tdata,
  // point_valid, circle_done
  output logic [1:0]                                m_tuser,
  output logic                                      m_tlast
);
  import mcp_pkg::*;

  localparam int OUT_BITS  = COORD_BITS + 1;
  localparam int TDATA_W   = ((2 * OUT_BITS + 7) / 8) * 8;
  localparam int SUM_W     = (OUT_BITS > RADIUS_BITS + 1) ? OUT_BITS : RADIUS_BITS + 1;

  logic [IDX_BITS-1:0]    idx;
  logic [IDX_BITS-1:0]    idx_next;
  logic [IDX_BITS-1:0]    last_idx;
  logic                   issue;
  logic                   is_last;

  logic [RADIUS_BITS-1:0] mag_x;
  logic [RADIUS_BITS-1:0] mag_y;
  logic                   neg_x;
  logic                   neg_y;
  logic                   pt_valid;
  logic [SUM_W-1:0]       sum_x;
  logic [SUM_W-1:0]       sum_y;

  logic                   out_valid;
  logic [OUT_BITS-1:0]    out_x;
  logic [OUT_BITS-1:0]    out_y;
  logic                   out_pv;
  logic                   out_done;
  logic                   out_last;

  // Index of the last result per burst kind
  always_comb begin
    case (burst_ctrl.kind)
      KIND_AXIS, KIND_QUAD: last_idx = IDX_BITS'(3);
      KIND_OCT:             last_idx = IDX_BITS'(7);
      default:              last_idx = '0;
    endcase
  end

  assign issue      = burst_valid && (!out_valid || m_tready);
  assign is_last    = (idx == last_idx);
  assign burst_take = issue && is_last;
  assign idx_next   = is_last ? '0 : idx + 1'b1;

  // Offsets: quad/oct: idx[0] mirrors x, idx[1] mirrors y, idx[2] swaps axes; axis: idx[1] picks y, idx[0] mirrors
  always_comb begin
    mag_x    = '0;
    mag_y    = '0;
    neg_x    = 1'b0;
    neg_y    = 1'b0;
    pt_valid = 1'b1;
    case (burst_ctrl.kind)
      KIND_AXIS: begin
        if (!idx[1]) begin
          mag_x = burst_dx;
          neg_x = idx[0];
        end else begin
          mag_y = burst_dx;
          neg_y = idx[0];
        end
      end
      KIND_QUAD, KIND_OCT: begin
        mag_x = idx[2] ? burst_dy : burst_dx;
        mag_y = idx[2] ? burst_dx : burst_dy;
        neg_x = idx[0];
        neg_y = idx[1];
      end
      KIND_CENTRE: pt_valid = 1'b1;
      default:     pt_valid = 1'b0;
    endcase
  end

  // Translate by the centre; wraps modulo the output width
  always_comb begin
    sum_x = neg_x
      ? {{(SUM_W-COORD_BITS){burst_cx[COORD_BITS-1]}}, burst_cx}
        - {{(SUM_W-RADIUS_BITS){1'b0}}, mag_x}
      : {{(SUM_W-COORD_BITS){burst_cx[COORD_BITS-1]}}, burst_cx}
        + {{(SUM_W-RADIUS_BITS){1'b0}}, mag_x};
    sum_y = neg_y
      ? {{(SUM_W-COORD_BITS){burst_cy[COORD_BITS-1]}}, burst_cy}
        - {{(SUM_W-RADIUS_BITS){1'b0}}, mag_y}
      : {{(SUM_W-COORD_BITS){burst_cy[COORD_BITS-1]}}, burst_cy}
        + {{(SUM_W-RADIUS_BITS){1'b0}}, mag_y};
  end

  // Index counter and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (issue) begin
      idx       <= idx_next;
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (issue) begin
      out_x    <= pt_valid ? sum_x[OUT_BITS-1:0] : '0;
      out_y    <= pt_valid ? sum_y[OUT_BITS-1:0] : '0;
      out_pv   <= pt_valid;
      out_done <= burst_ctrl.done;
      out_last <= is_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TDATA_W-2*OUT_BITS){1'b0}}, out_y, out_x};
  assign m_tuser  = {out_done, out_pv};
  assign m_tlast  = out_last;

endmodule

### rtl/midpoint_circle_points_top.sv
// Midpoint circle point generator, top level: octant stepper and burst register.
// Depends on mcp_pkg and mcp_emit.
//
// Each input transfer is one command: tuser 0 starts a circle at the given centre and
// radius, tuser 1 advances the octant by one step. The stepper updates its state in the
// cycle the command is taken and parks the resulting burst in a one-deep register; the
// emitter sends the burst out one result per cycle when unstalled, via a registered output.
// A start yields four axis points (one point for radius zero), a step yields eight
// points (four on the diagonal), and a step past the end or with no circle active
// yields one invalid result flagged done; tlast marks the final result of each command.
// The command waits in the burst register and each result is registered in the emitter's
// output register before it appears. Full octant steps are limited by the single result
// port, as a burst leaves one result at a time; the next command is taken in the cycle
// the current burst issues its last result into the output register.
module midpoint_circle_points_top #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              s_tvalid,
  output logic                                              s_tready,
  // centre_x, centre_y, radius, zero pad
  input  logic [(((2*COORD_BITS+RADIUS_BITS)+7)/8)*8-1:0]   s_tdata,
  // action
  input  logic                                              s_tuser,
  output logic                                              m_tvalid,
  input  logic                                              m_tready,
  // point_x, point_y, zero pad
  output logic [(((2*(COORD_BITS+1))+7)/8)*8-1:0]           m_tdata,
  // point_valid, circle_done
  output logic [1:0]                                        m_tuser,
  output logic                                              m_tlast
);
  import mcp_pkg::*;

  localparam int DEC_BITS = RADIUS_BITS + 3;

  // Command fields
  logic                   accept;
  logic [COORD_BITS-1:0]  in_cx;
  logic [COORD_BITS-1:0]  in_cy;
  logic [RADIUS_BITS-1:0] in_r;

  // Octant state
  logic [RADIUS_BITS-1:0] octant_x;
  logic [RADIUS_BITS-1:0] octant_y;
  logic [DEC_BITS-1:0]    decision;
  logic [COORD_BITS-1:0]  saved_centre_x;
  logic [COORD_BITS-1:0]  saved_centre_y;
  logic                   running;

  logic [RADIUS_BITS-1:0] octant_x_next;
  logic [RADIUS_BITS-1:0] octant_y_next;
  logic [DEC_BITS-1:0]    decision_next;
  logic [COORD_BITS-1:0]  saved_centre_x_next;
  logic [COORD_BITS-1:0]  saved_centre_y_next;
  logic                   running_next;

  // Step arithmetic
  logic [RADIUS_BITS-1:0] y_inc;
  logic [RADIUS_BITS-1:0] x_dec;
  logic                   dec_pos;
  logic [RADIUS_BITS-1:0] x_new;
  logic [DEC_BITS-1:0]    two_y_plus1;
  logic [DEC_BITS-1:0]    two_x;

  // Burst register
  logic                   burst_valid;
  burst_ctrl_t            burst_ctrl;
  logic [COORD_BITS-1:0]  burst_cx;
  logic [COORD_BITS-1:0]  burst_cy;
  logic [RADIUS_BITS-1:0] burst_dx;
  logic [RADIUS_BITS-1:0] burst_dy;
  logic                   burst_take;

  burst_ctrl_t            burst_ctrl_next;
  logic [RADIUS_BITS-1:0] burst_dx_next;
  logic [RADIUS_BITS-1:0] burst_dy_next;

  assign in_cx    = s_tdata[COORD_BITS-1:0];
  assign in_cy    = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_r     = s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
  assign s_tready = !burst_valid || burst_take;
  assign accept   = s_tvalid && s_tready;

  // One midpoint iteration
  assign y_inc       = octant_y + 1'b1;
  assign x_dec       = octant_x - 1'b1;
  assign dec_pos     = $signed(decision) > 0;
  assign x_new       = dec_pos ? x_dec : octant_x;
  assign two_y_plus1 = {2'b00, y_inc, 1'b1};
  assign two_x       = {2'b00, x_dec, 1'b0};

  // Next state and burst for the command at the input
  always_comb begin
    octant_x_next       = octant_x;
    octant_y_next       = octant_y;
    decision_next       = decision;
    saved_centre_x_next = saved_centre_x;
    saved_centre_y_next = saved_centre_y;
    running_next        = 1'b0;
    burst_ctrl_next     = '{kind: KIND_INVALID, done: 1'b1};
    burst_dx_next       = '0;
    burst_dy_next       = '0;
    if (!s_tuser) begin
      // start: load centre, point (r, 0), decision 1 - r
      saved_centre_x_next = in_cx;
      saved_centre_y_next = in_cy;
      octant_x_next       = in_r;
      octant_y_next       = '0;
      decision_next       = DEC_BITS'(1) - {3'b000, in_r};
      burst_dx_next       = in_r;
      if (in_r == '0) begin
        burst_ctrl_next = '{kind: KIND_CENTRE, done: 1'b1};
      end else begin
        running_next    = 1'b1;
        burst_ctrl_next = '{kind: KIND_AXIS, done: 1'b0};
      end
    end else if (running && (octant_x > octant_y)) begin
      // advance: y + 1, x - 1 when the midpoint lies outside
      octant_x_next = x_new;
      octant_y_next = y_inc;
      decision_next = dec_pos ? decision + two_y_plus1 - two_x : decision + two_y_plus1;
      burst_dx_next = x_new;
      burst_dy_next = y_inc;
      if (x_new > y_inc) begin
        running_next    = 1'b1;
        burst_ctrl_next = '{kind: KIND_OCT, done: 1'b0};
      end else if (x_new == y_inc) begin
        burst_ctrl_next = '{kind: KIND_QUAD, done: 1'b1};
      end
    end
  end

  // Octant state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octant_x       <= '0;
      octant_y       <= '0;
      decision       <= '0;
      saved_centre_x <= '0;
      saved_centre_y <= '0;
      running        <= 1'b0;
    end else if (accept) begin
      octant_x       <= octant_x_next;
      octant_y       <= octant_y_next;
      decision       <= decision_next;
      saved_centre_x <= saved_centre_x_next;
      saved_centre_y <= saved_centre_y_next;
      running        <= running_next;
    end
  end

  // Burst register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
    end else if (accept) begin
      burst_valid <= 1'b1;
    end else if (burst_take) begin
      burst_valid <= 1'b0;
    end
  end

  // Burst payload, carries the centre in force when the command was taken
  always_ff @(posedge clk) begin
    if (accept) begin
      burst_ctrl <= burst_ctrl_next;
      burst_cx   <= saved_centre_x_next;
      burst_cy   <= saved_centre_y_next;
      burst_dx   <= burst_dx_next;
      burst_dy   <= burst_dy_next;
    end
  end

  mcp_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .burst_valid (burst_valid),
    .burst_ctrl  (burst_ctrl),
    .burst_cx    (burst_cx),
    .burst_cy    (burst_cy),
    .burst_dx    (burst_dx),
    .burst_dy    (burst_dy),
    .burst_take  (burst_take),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

`ifndef SYNTHESIS
  // An active circle always has its octant point above the diagonal
  a_running_octant: assert property (@(posedge clk) disable iff (rst)
    running |-> (octant_x > octant_y))
    else $error("running with octant_x not above octant_y");

  // A result without a point always ends its command and the circle
  a_invalid_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tuser[1] && m_tlast))
    else $error("invalid result not flagged done and last");

  // A zero-radius start never leaves a circle active
  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser && (in_r == '0)) |=> !running)
    else $error("zero radius start left circle running");

  // A stalled input means a burst is still waiting for the emitter
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> burst_valid)
    else $error("input stalled without a pending burst");
`endif

endmodule
